FILE: src/rfdc_pkg.sv
// Shared types, constants and helpers for the relay filter with duplicate cache.
package rfdc_pkg;

    // Cache geometry
    localparam int CACHE_DEPTH = 10;
    localparam int PTR_W       = $clog2(CACHE_DEPTH);
    localparam int CNT_W       = $clog2(CACHE_DEPTH + 1);
    localparam int KEY_W       = 32;

    // Field widths
    localparam int ID_W     = 8;
    localparam int SEQ_W    = 16;
    localparam int ACTION_W = 3;

    // Stream payload widths (whole bytes)
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 16;

    // Configuration port
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_NODE_ID     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = CFG_IDX_W'(2);

    localparam logic [ID_W-1:0] NODE_ID_RESET = ID_W'(3);

    typedef enum logic [ACTION_W-1:0] {
        ACT_BAD       = 3'd0,
        ACT_EXPIRED   = 3'd1,
        ACT_DELIVER   = 3'd2,
        ACT_DUPLICATE = 3'd3,
        ACT_RELAY     = 3'd4,
        ACT_OFF_PATH  = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_LOOKUP,
        ST_EMIT
    } top_state_t;

    typedef enum logic {
        C_IDLE,
        C_SCAN
    } cache_state_t;

    // Received header as packed on the input stream, lowest field last here
    typedef struct packed {
        logic [ID_W-1:0]  hop_limit;
        logic [SEQ_W-1:0] sequence_number;
        logic [ID_W-1:0]  packet_type;
        logic [ID_W-1:0]  dest_id;
        logic [ID_W-1:0]  source_id;
        logic [ID_W-1:0]  sync_second;
        logic [ID_W-1:0]  sync_first;
        logic             rx_ok;
    } hdr_t;

    typedef struct packed {
        logic             start;
        logic [KEY_W-1:0] key;
    } cache_req_t;

    typedef struct packed {
        logic done;
        logic hit;
    } cache_resp_t;

    // Add two ring positions modulo the cache depth
    function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] a,
                                                  input logic [PTR_W-1:0] b);
        logic [PTR_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (PTR_W+1)'(CACHE_DEPTH)) begin
            s = s - (PTR_W+1)'(CACHE_DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

endpackage

FILE: src/relay_filter_with_dedup_cache_top.sv
// Relay filter top level: header classification, cache lookup control and stream ports.
// Flow: accept, a classify state, then for headers needing the duplicate check a cache
//   search (one entry per cycle, ending early on a hit, fill at most CACHE_DEPTH), then
//   the output register. A new header is taken only after the last result is loaded into
//   the output register; a single comparator walks the cache memory for the search.
// Reset (aresetn, synchronous, active low) empties the cache and restores node_id 3 and
//   both sync bytes to 0; no clearing pass is needed.
module relay_filter_with_dedup_cache_top import rfdc_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input headers
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // s_tdata: rx_ok[0], sync_first[8:1], sync_second[16:9], source_id[24:17],
    //          dest_id[32:25], packet_type[40:33], sequence_number[56:41],
    //          hop_limit[64:57], zero pad[71:65]
    input  logic [S_DATA_W-1:0]  s_tdata,
    // Results
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // m_tdata: action[2:0], hop_limit_out[10:3], zero pad[15:11]
    output logic [M_DATA_W-1:0]  m_tdata,
    // Configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ID_W-1:0]      cfg_data
);

    top_state_t      state_reg, state_next;
    hdr_t            hdr_reg;
    logic [ID_W-1:0] node_id_reg, sync1_reg, sync2_reg;
    logic            local_reg, local_next;
    logic [ID_W-1:0] hop_dec_reg, hop_dec_next;
    action_t         res_act_reg, res_act_next;
    logic [ID_W-1:0] res_hop_reg, res_hop_next;
    logic            m_tvalid_reg, m_tvalid_next;
    action_t         out_act_reg;
    logic [ID_W-1:0] out_hop_reg;
    logic            load_out;

    cache_req_t  creq;
    cache_resp_t cresp;

    logic [ID_W-1:0] hop_dec;
    logic            bad, down, up;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {(M_DATA_W - ACTION_W - ID_W)'(0), out_hop_reg, out_act_reg};

    // Configuration registers; unknown indexes are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_id_reg <= NODE_ID_RESET;
            sync1_reg   <= '0;
            sync2_reg   <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_NODE_ID:     node_id_reg <= cfg_data;
                REG_SYNC_FIRST:  sync1_reg   <= cfg_data;
                REG_SYNC_SECOND: sync2_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Hold the accepted header
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            hdr_reg <= hdr_t'(s_tdata[$bits(hdr_t)-1:0]);
        end
    end

    // Classification terms
    assign hop_dec = hdr_reg.hop_limit - 1'b1;
    assign bad     = !hdr_reg.rx_ok || (hdr_reg.sync_first != sync1_reg)
                     || (hdr_reg.sync_second != sync2_reg);
    assign down    = (hdr_reg.source_id < node_id_reg) && (hdr_reg.dest_id > node_id_reg);
    assign up      = (hdr_reg.source_id > node_id_reg) && (hdr_reg.dest_id < node_id_reg);

    rfdc_cache u_cache (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (creq),
        .resp    (cresp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        local_reg   <= local_next;
        hop_dec_reg <= hop_dec_next;
        res_act_reg <= res_act_next;
        res_hop_reg <= res_hop_next;
        if (load_out) begin
            out_act_reg <= res_act_reg;
            out_hop_reg <= res_hop_reg;
        end
    end

    // Decide, look up, then hand the result to the output register
    always_comb begin
        state_next    = state_reg;
        local_next    = local_reg;
        hop_dec_next  = hop_dec_reg;
        res_act_next  = res_act_reg;
        res_hop_next  = res_hop_reg;
        creq.start    = 1'b0;
        creq.key      = {hdr_reg.source_id, hdr_reg.packet_type, hdr_reg.sequence_number};
        load_out      = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY: begin
                hop_dec_next = hop_dec;
                res_hop_next = '0;
                if (bad) begin
                    res_act_next = ACT_BAD;
                    state_next   = ST_EMIT;
                end else if (hdr_reg.hop_limit == '0) begin
                    res_act_next = ACT_EXPIRED;
                    state_next   = ST_EMIT;
                end else if (hdr_reg.dest_id == node_id_reg) begin
                    local_next = 1'b1;
                    creq.start = 1'b1;
                    state_next = ST_LOOKUP;
                end else if (hop_dec == '0) begin
                    res_act_next = ACT_EXPIRED;
                    state_next   = ST_EMIT;
                end else if (!(down || up)) begin
                    res_act_next = ACT_OFF_PATH;
                    state_next   = ST_EMIT;
                end else begin
                    local_next = 1'b0;
                    creq.start = 1'b1;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (cresp.done) begin
                    res_hop_next = hop_dec_reg;
                    if (cresp.hit) begin
                        res_act_next = ACT_DUPLICATE;
                    end else if (local_reg) begin
                        res_act_next = ACT_DELIVER;
                    end else begin
                        res_act_next = ACT_RELAY;
                    end
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    load_out      = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // A result is only loaded in the emit state and never over an untaken one
    a_load_safe: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> ((state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready)))
        else $error("result register overwritten");

    // Cache responses arrive only while a lookup is pending
    a_resp_in_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        cresp.done |-> (state_reg == ST_LOOKUP))
        else $error("unexpected cache response");

    // Actions that skip the cache always carry a zero hop count
    a_hop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && (out_act_reg == ACT_BAD || out_act_reg == ACT_EXPIRED
                          || out_act_reg == ACT_OFF_PATH)) |-> (out_hop_reg == '0))
        else $error("nonzero hop count on dropped header");

endmodule

FILE: src/rfdc_cache.sv
// Duplicate-key cache: ring memory searched one entry per cycle by a shared comparator.
module rfdc_cache import rfdc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  cache_req_t  req,
    output cache_resp_t resp
);

    localparam logic [CNT_W-1:0] FILL_MAX  = CNT_W'(CACHE_DEPTH);
    localparam logic [PTR_W-1:0] HEAD_LAST = PTR_W'(CACHE_DEPTH - 1);

    logic [KEY_W-1:0] mem_q [CACHE_DEPTH];
    logic [KEY_W-1:0] rd_data_reg;
    logic [KEY_W-1:0] key_reg;

    cache_state_t     state_reg, state_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic             pend_reg, pend_next;

    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    logic [PTR_W-1:0] rd_addr;
    logic             match;

    // Shared comparator: the one entry read last cycle against the key
    assign match   = pend_reg && (rd_data_reg == key_reg);
    assign rd_addr = ring_add(head_reg, idx_reg[PTR_W-1:0]);

    // Memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_q[wr_addr] <= key_reg;
        end
        rd_data_reg <= mem_q[rd_addr];
    end

    // Latch the key of a new search
    always_ff @(posedge aclk) begin
        if (req.start && state_reg == C_IDLE) begin
            key_reg <= req.key;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            idx_reg   <= '0;
            fill_reg  <= '0;
            head_reg  <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            fill_reg  <= fill_next;
            head_reg  <= head_next;
            pend_reg  <= pend_next;
        end
    end

    // Sequence the search, then insert on a miss
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        fill_next  = fill_reg;
        head_next  = head_reg;
        pend_next  = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = head_reg;
        resp.done  = 1'b0;
        resp.hit   = 1'b0;
        unique case (state_reg)
            C_IDLE: begin
                if (req.start) begin
                    idx_next   = '0;
                    state_next = C_SCAN;
                end
            end
            C_SCAN: begin
                if (match) begin
                    resp.done  = 1'b1;
                    resp.hit   = 1'b1;
                    state_next = C_IDLE;
                end else if (idx_reg < fill_reg) begin
                    idx_next  = idx_reg + 1'b1;
                    pend_next = 1'b1;
                end else begin
                    // Miss: append, or overwrite the oldest once full
                    wr_en      = 1'b1;
                    resp.done  = 1'b1;
                    state_next = C_IDLE;
                    if (fill_reg < FILL_MAX) begin
                        wr_addr   = ring_add(head_reg, fill_reg[PTR_W-1:0]);
                        fill_next = fill_reg + 1'b1;
                    end else begin
                        wr_addr   = head_reg;
                        head_next = (head_reg == HEAD_LAST) ? '0 : head_reg + 1'b1;
                    end
                end
            end
            default: state_next = C_IDLE;
        endcase
    end

    // Fill count never passes the depth
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_MAX)
        else $error("cache fill count beyond depth");

    // Fill grows by one at most, and only on a completed miss
    a_fill_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg != $past(fill_reg)) |-> (fill_reg == $past(fill_reg) + 1'b1))
        else $error("cache fill count jumped");

    // Oldest entry only rotates out while the cache is full
    a_head_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (head_reg != $past(head_reg)) |-> ($past(fill_reg) == FILL_MAX))
        else $error("head moved before cache filled");

    // A search is only started while the cache sequencer is idle
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> (state_reg == C_IDLE))
        else $error("search started while busy");

endmodule
